/* design/nfcp_pkg.sv */
// ----------------------------------------------------------------------------
// NFC response frame parser package
// Shared types, codes and reset constants for the frame parser.
// ----------------------------------------------------------------------------
package nfcp_pkg;

  // Request command codes
  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  // Completion status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_INVALID = 2'd2,
    ST_NOSPACE = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SENT_COMMAND = 2'd0,
    CFG_BUFFER_CAP   = 2'd1,
    CFG_TIMEOUT      = 2'd2,
    CFG_HOST_DIR     = 2'd3
  } cfg_idx_e;

  // Parser phases, one per receive group plus idle
  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_PRE  = 4'd1,
    PH_LEN  = 4'd2,
    PH_TFI  = 4'd3,
    PH_DATA = 4'd4,
    PH_DCS  = 4'd5
  } phase_e;

  // Result kind
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Frame constants
  localparam logic [7:0] START_CODE   = 8'hFF;
  localparam logic [7:0] ZERO_BYTE    = 8'h00;
  localparam logic [7:0] TFI_OVERHEAD = 8'd2;
  localparam logic [7:0] PRE_LAST_IDX = 8'd2;
  localparam logic [7:0] PRE_BYTES    = 8'd3;

  // Configuration reset values
  localparam logic [7:0]  RST_SENT_COMMAND = 8'd0;
  localparam logic [7:0]  RST_BUFFER_CAP   = 8'd255;
  localparam logic [15:0] RST_TIMEOUT      = 16'd1000;
  localparam logic [7:0]  RST_HOST_DIR     = 8'd213;

  localparam int unsigned CFG_DATA_W = 16;

  // One result item
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    status_e    status;
    logic [7:0] payload_length;
    logic       last;
  } rsp_t;

endpackage

/* design/nfcp_if.sv */
// ----------------------------------------------------------------------------
// NFC response frame parser channels
// Valid/ready request and result channels of the frame parser.
// ----------------------------------------------------------------------------
interface nfcp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface nfcp_rsp_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [1:0] status;
  logic [7:0] payload_length;
  logic       last;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output status, output payload_length, output last, input ready);
  modport sink (input valid, input kind, input data_byte, input byte_index,
                input status, input payload_length, input last, output ready);
endinterface

/* design/nfc_response_frame_parser.sv */
// ----------------------------------------------------------------------------
// NFC response frame parser
// Parses a controller response frame from a received byte stream.
// ----------------------------------------------------------------------------
// One request (received byte, millisecond tick or start) is taken every clock
// cycle; the frame state is updated at the accepting edge and any result
// (payload byte or completion status) appears in the output register on the
// next cycle. The only back-pressure comes from that single output register:
// req_i.ready drops only while a result is held and the sink is stalling.
// Configuration registers may be written only while the parser is idle.
module nfc_response_frame_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  nfcp_req_if.sink                           req_i,
  nfcp_rsp_if.source                         rsp_o,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [nfcp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import nfcp_pkg::*;

  // Configuration registers
  logic [7:0]  sent_cmd_q, buf_cap_q, host_dir_q;
  logic [15:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_cmd_q <= RST_SENT_COMMAND;
      buf_cap_q  <= RST_BUFFER_CAP;
      timeout_q  <= RST_TIMEOUT;
      host_dir_q <= RST_HOST_DIR;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SENT_COMMAND: sent_cmd_q <= cfg_data_i[7:0];
        CFG_BUFFER_CAP:   buf_cap_q  <= cfg_data_i[7:0];
        CFG_TIMEOUT:      timeout_q  <= cfg_data_i[15:0];
        CFG_HOST_DIR:     host_dir_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Frame state
  phase_e      phase_q, phase_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  remain_q, remain_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  hold_q, hold_d;
  logic        bad_q, bad_d;

  logic       accept;
  logic       room;
  logic       rsp_load;
  rsp_t       rsp_d;
  rsp_t       rsp_q;
  logic       rsp_valid;

  logic [7:0] exp_code;
  logic [7:0] b;
  logic [7:0] pre_exp;
  logic [7:0] count_inc;
  logic       pre_bad;

  assign req_i.ready = room;
  assign accept      = req_i.valid && room;
  assign b           = req_i.rx_byte;
  assign exp_code    = sent_cmd_q + 8'd1;
  assign count_inc   = count_q + 8'd1;
  assign pre_exp     = (count_q == PRE_LAST_IDX) ? START_CODE : ZERO_BYTE;
  assign pre_bad     = bad_q || (b != pre_exp);

  // Next state and result for the accepted request
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    remain_d = remain_q;
    sum_d    = sum_q;
    tick_d   = tick_q;
    hold_d   = hold_q;
    bad_d    = bad_q;
    rsp_load = 1'b0;
    rsp_d    = '{kind: KIND_DONE, data_byte: '0, byte_index: '0, status: ST_OK,
                 payload_length: '0, last: 1'b1};

    if (accept) begin
      if (cmd_e'(req_i.cmd) == CMD_START) begin
        remain_d = '0;
        sum_d    = '0;
        hold_d   = '0;
        phase_d  = PH_PRE;
        count_d  = '0;
        tick_d   = '0;
        bad_d    = 1'b0;
      end else if (phase_q != PH_IDLE) begin
        case (cmd_e'(req_i.cmd))
          // Millisecond tick: timeout check, saturating count
          CMD_TICK: begin
            if (timeout_q != '0 && tick_q >= timeout_q) begin
              rsp_load     = 1'b1;
              rsp_d.status = ST_TIMEOUT;
            end else if (tick_q != '1) begin
              tick_d = tick_q + 16'd1;
            end
          end
          // Received byte
          CMD_BYTE: begin
            case (phase_q)
              PH_PRE: begin
                bad_d   = pre_bad;
                count_d = count_inc;
                if (count_inc >= PRE_BYTES) begin
                  if (pre_bad) begin
                    rsp_load     = 1'b1;
                    rsp_d.status = ST_INVALID;
                  end else begin
                    phase_d = PH_LEN;
                    count_d = '0;
                    tick_d  = '0;
                    bad_d   = 1'b0;
                  end
                end
              end
              PH_LEN: begin
                if (count_q == '0) begin
                  hold_d  = b;
                  count_d = 8'd1;
                end else if (8'(hold_q + b) != '0) begin
                  rsp_load     = 1'b1;
                  rsp_d.status = ST_INVALID;
                end else begin
                  remain_d = hold_q - TFI_OVERHEAD;
                  if (remain_d > buf_cap_q) begin
                    rsp_load     = 1'b1;
                    rsp_d.status = ST_NOSPACE;
                  end else begin
                    phase_d = PH_TFI;
                    count_d = '0;
                    tick_d  = '0;
                    bad_d   = 1'b0;
                  end
                end
              end
              PH_TFI: begin
                if (count_q == '0) begin
                  hold_d  = b;
                  count_d = 8'd1;
                end else if (hold_q != host_dir_q || b != exp_code) begin
                  rsp_load     = 1'b1;
                  rsp_d.status = ST_INVALID;
                end else begin
                  sum_d   = host_dir_q + exp_code;
                  phase_d = (remain_q == '0) ? PH_DCS : PH_DATA;
                  count_d = '0;
                  tick_d  = '0;
                  bad_d   = 1'b0;
                end
              end
              // Payload byte goes straight out
              PH_DATA: begin
                rsp_load         = 1'b1;
                rsp_d.kind       = KIND_DATA;
                rsp_d.data_byte  = b;
                rsp_d.byte_index = count_q;
                rsp_d.last       = 1'b0;
                sum_d            = sum_q + b;
                count_d          = count_inc;
                if (count_inc >= remain_q) begin
                  phase_d = PH_DCS;
                  count_d = '0;
                  tick_d  = '0;
                  bad_d   = 1'b0;
                end
              end
              PH_DCS: begin
                if (count_q == '0) begin
                  hold_d  = b;
                  count_d = 8'd1;
                end else begin
                  rsp_load = 1'b1;
                  if (8'(sum_q + hold_q) != '0 || b != ZERO_BYTE) begin
                    rsp_d.status = ST_INVALID;
                  end else begin
                    rsp_d.status         = ST_OK;
                    rsp_d.payload_length = remain_q;
                  end
                end
              end
              default: begin
                phase_d = PH_IDLE;
                count_d = '0;
                tick_d  = '0;
                bad_d   = 1'b0;
              end
            endcase
          end
          default: ;
        endcase

        // Any completion returns to idle
        if (rsp_load && rsp_d.kind == KIND_DONE) begin
          phase_d = PH_IDLE;
          count_d = '0;
          tick_d  = '0;
          bad_d   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      count_q  <= '0;
      remain_q <= '0;
      sum_q    <= '0;
      tick_q   <= '0;
      hold_q   <= '0;
      bad_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      sum_q    <= sum_d;
      tick_q   <= tick_d;
      hold_q   <= hold_d;
      bad_q    <= bad_d;
    end
  end

  // Result register
  nfcp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (rsp_load),
    .data_i  (rsp_d),
    .room_o  (room),
    .ready_i (rsp_o.ready),
    .valid_o (rsp_valid),
    .data_o  (rsp_q)
  );

  assign rsp_o.valid          = rsp_valid;
  assign rsp_o.kind           = rsp_q.kind;
  assign rsp_o.data_byte      = rsp_q.data_byte;
  assign rsp_o.byte_index     = rsp_q.byte_index;
  assign rsp_o.status         = rsp_q.status;
  assign rsp_o.payload_length = rsp_q.payload_length;
  assign rsp_o.last           = rsp_q.last;

  // Assertions
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> (tick_q == '0 && count_q == '0 && !bad_q))
    else $error("idle phase with stale group state");

  a_data_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> count_q < remain_q)
    else $error("payload index past payload length");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |-> !req_i.ready)
    else $error("request taken while result register is stalled");

  a_fail_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.last && rsp_o.status != ST_OK) |-> rsp_o.payload_length == '0)
    else $error("failed completion carries a payload length");

endmodule

/* design/nfcp_out_stage.sv */
// ----------------------------------------------------------------------------
// NFC response frame parser output stage
// Result register with valid/ready handshake toward the sink.
// ----------------------------------------------------------------------------
module nfcp_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  nfcp_pkg::rsp_t data_i,
  output logic          room_o,
  input  logic          ready_i,
  output logic          valid_o,
  output nfcp_pkg::rsp_t data_o
);
  import nfcp_pkg::*;

  logic valid_q, valid_d;
  rsp_t data_q;

  // Slot is free when empty or being drained this cycle
  assign room_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* verif/nfcp_frame_checker.sv */
// ----------------------------------------------------------------------------
// NFC response frame parser checker
// Watches the request, result and register ports, predicts every result of
// the parser and compares accepted results against them in order.
// ----------------------------------------------------------------------------
module nfcp_frame_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  nfcp_req_if                             req_i,
  nfcp_rsp_if                             rsp_i,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [nfcp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  import nfcp_pkg::*;

  // Register copies
  logic [7:0]  sent_cmd;
  logic [7:0]  buf_cap;
  logic [15:0] timeout_lim;
  logic [7:0]  host_dir;

  // Parser state
  phase_e      phase_q;
  logic [7:0]  grp_cnt;
  logic [7:0]  pay_len;
  logic [7:0]  dsum;
  logic [15:0] ticks;
  logic [7:0]  held;
  logic        grp_bad;

  rsp_t        frame_results_q[$];
  int unsigned errors;

  task automatic open_group(input phase_e ph);
    phase_q = ph;
    grp_cnt = 8'd0;
    ticks   = 16'd0;
    grp_bad = 1'b0;
  endtask

  // Completion item; length is reported only on success
  task automatic close_frame(input status_e st, input logic [7:0] len);
    rsp_t r;
    r.kind           = KIND_DONE;
    r.data_byte      = 8'd0;
    r.byte_index     = 8'd0;
    r.status         = st;
    r.payload_length = (st == ST_OK) ? len : 8'd0;
    r.last           = 1'b1;
    frame_results_q.push_back(r);
    open_group(PH_IDLE);
  endtask

  // Advance the parser by one request
  task automatic parse_request(input logic [1:0] cmd, input logic [7:0] b);
    logic [7:0] code;
    logic [7:0] s;
    rsp_t       r;
    code = sent_cmd + 8'd1;
    if (cmd == CMD_START) begin
      pay_len = 8'd0;
      dsum    = 8'd0;
      held    = 8'd0;
      open_group(PH_PRE);
    end else if (cmd == CMD_TICK && phase_q != PH_IDLE) begin
      if (timeout_lim != 16'd0 && ticks >= timeout_lim) begin
        close_frame(ST_TIMEOUT, 8'd0);
      end else if (ticks != 16'hFFFF) begin
        ticks = ticks + 16'd1;
      end
    end else if (cmd == CMD_BYTE && phase_q != PH_IDLE) begin
      case (phase_q)
        PH_PRE: begin
          if (b != ((grp_cnt == PRE_LAST_IDX) ? START_CODE : ZERO_BYTE)) grp_bad = 1'b1;
          grp_cnt = grp_cnt + 8'd1;
          if (grp_cnt >= PRE_BYTES) begin
            if (grp_bad) close_frame(ST_INVALID, 8'd0);
            else open_group(PH_LEN);
          end
        end
        PH_LEN: begin
          if (grp_cnt == 8'd0) begin
            held    = b;
            grp_cnt = 8'd1;
          end else begin
            s = held + b;
            if (s != 8'd0) begin
              close_frame(ST_INVALID, 8'd0);
            end else begin
              pay_len = held - TFI_OVERHEAD;
              if (pay_len > buf_cap) close_frame(ST_NOSPACE, 8'd0);
              else open_group(PH_TFI);
            end
          end
        end
        PH_TFI: begin
          if (grp_cnt == 8'd0) begin
            held    = b;
            grp_cnt = 8'd1;
          end else if (held != host_dir || b != code) begin
            close_frame(ST_INVALID, 8'd0);
          end else begin
            dsum = host_dir + code;
            if (pay_len == 8'd0) open_group(PH_DCS);
            else open_group(PH_DATA);
          end
        end
        PH_DATA: begin
          r.kind           = KIND_DATA;
          r.data_byte      = b;
          r.byte_index     = grp_cnt;
          r.status         = ST_OK;
          r.payload_length = 8'd0;
          r.last           = 1'b0;
          frame_results_q.push_back(r);
          dsum    = dsum + b;
          grp_cnt = grp_cnt + 8'd1;
          if (grp_cnt >= pay_len) open_group(PH_DCS);
        end
        PH_DCS: begin
          if (grp_cnt == 8'd0) begin
            held    = b;
            grp_cnt = 8'd1;
          end else begin
            s = dsum + held;
            if (s != 8'd0 || b != ZERO_BYTE) close_frame(ST_INVALID, 8'd0);
            else close_frame(ST_OK, pay_len);
          end
        end
        default: open_group(PH_IDLE);
      endcase
    end
  endtask

  task automatic cmp_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Compare one accepted result with the oldest prediction
  task automatic check_result();
    rsp_t want;
    if (frame_results_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual kind %0d data %0d status %0d",
               $time, rsp_i.kind, rsp_i.data_byte, rsp_i.status);
    end else begin
      want = frame_results_q.pop_front();
      cmp_field("kind", 32'(want.kind), 32'(rsp_i.kind));
      cmp_field("data_byte", 32'(want.data_byte), 32'(rsp_i.data_byte));
      cmp_field("byte_index", 32'(want.byte_index), 32'(rsp_i.byte_index));
      cmp_field("status", 32'(want.status), 32'(rsp_i.status));
      cmp_field("payload_length", 32'(want.payload_length), 32'(rsp_i.payload_length));
      cmp_field("last", 32'(want.last), 32'(rsp_i.last));
    end
  endtask

  // Sample all ports at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_cmd    = RST_SENT_COMMAND;
      buf_cap     = RST_BUFFER_CAP;
      timeout_lim = RST_TIMEOUT;
      host_dir    = RST_HOST_DIR;
      pay_len     = 8'd0;
      dsum        = 8'd0;
      held        = 8'd0;
      open_group(PH_IDLE);
      frame_results_q.delete();
      errors        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SENT_COMMAND: sent_cmd    = cfg_data_i[7:0];
          CFG_BUFFER_CAP:   buf_cap     = cfg_data_i[7:0];
          CFG_TIMEOUT:      timeout_lim = cfg_data_i[15:0];
          CFG_HOST_DIR:     host_dir    = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) parse_request(req_i.cmd, req_i.rx_byte);
      if (rsp_i.valid && rsp_i.ready) check_result();
      fail_count_o <= errors;
      pending_o    <= frame_results_q.size();
    end
  end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// NFC response frame parser testbench
// Drives directed and random response frames with register changes, bursty
// request timing and a stalling result sink; the checker judges the results.
// ----------------------------------------------------------------------------
module testbench;
  import nfcp_pkg::*;

  localparam int unsigned RUN_ITEMS    = 1200;
  localparam int unsigned NUM_SETTINGS = 6;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DIRECTED_LEN = 25;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  // {cmd, rx_byte}: idle noise, good empty frame with wrapped response code,
  // restart mid-preamble then bad byte and timeout, oversized length
  localparam logic [9:0] DIRECTED [DIRECTED_LEN] = '{
    {CMD_BYTE, 8'hA5}, {CMD_TICK, 8'h5A}, {CMD_UNUSED, 8'hFF},
    {CMD_START, 8'h00}, {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'hFF},
    {CMD_BYTE, 8'h02}, {CMD_BYTE, 8'hFE}, {CMD_BYTE, 8'hD5}, {CMD_BYTE, 8'h00},
    {CMD_BYTE, 8'h2B}, {CMD_BYTE, 8'h00},
    {CMD_START, 8'hFF}, {CMD_BYTE, 8'h00}, {CMD_START, 8'h00}, {CMD_BYTE, 8'h01},
    {CMD_TICK, 8'h00}, {CMD_TICK, 8'hFF},
    {CMD_START, 8'h00}, {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'hFF},
    {CMD_BYTE, 8'h05}, {CMD_BYTE, 8'hFB}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [1:0]            cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           cycles = 0;

  // Stimulus copy of the registers, used to build frames
  logic [7:0]  sent_cmd;
  logic [7:0]  buf_cap;
  logic [15:0] timeout_cfg;
  logic [7:0]  host_dir;

  int unsigned frame_items;
  int unsigned burst_left;
  bit          gaps_on;
  logic        long_hold_q;

  nfcp_req_if req_if ();
  nfcp_rsp_if rsp_if ();

  nfc_response_frame_parser i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  nfcp_frame_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run length guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result sink: rotating stall patterns plus one long hold-off
  initial begin : sink_pattern
    int unsigned hold_left;
    int unsigned rx_cyc;
    bit          hold_done;
    hold_left     = 0;
    rx_cyc        = 0;
    hold_done     = 1'b0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cyc++;
      if (long_hold_q && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case ((rx_cyc / 256) % 4)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
          2:       rsp_if.ready <= ((rx_cyc % 8) < 5);
          default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic idle_for(input int unsigned n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Offer one request and wait until it is taken; bursts end in random gaps while gaps_on is set
  task automatic offer_request(input logic [1:0] c, input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) idle_for($urandom_range(1, 6));
    end
    burst_left--;
    req_if.valid   <= 1'b1;
    req_if.cmd     <= c;
    req_if.rx_byte <= b;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic frame_request(input logic [1:0] c, input logic [7:0] b);
    offer_request(c, b);
    frame_items++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // Register update once every result is out and the parser has settled
  task automatic set_config(input logic [7:0] sc, input logic [7:0] cap,
                            input logic [15:0] to, input logic [7:0] dir);
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(CFG_SENT_COMMAND, {8'd0, sc});
    write_reg(CFG_BUFFER_CAP, {8'd0, cap});
    write_reg(CFG_TIMEOUT, to);
    write_reg(CFG_HOST_DIR, {8'd0, dir});
    cfg_we_i    <= 1'b0;
    sent_cmd    = sc;
    buf_cap     = cap;
    timeout_cfg = to;
    host_dir    = dir;
  endtask

  // One response frame with random content and an occasional fault
  task automatic send_frame();
    logic [7:0]  frame_q[$];
    logic [7:0]  len_b;
    logic [7:0]  code_b;
    logic [7:0]  sum;
    logic [7:0]  pb;
    logic [7:0]  flip;
    int unsigned paylen;
    int unsigned fault;
    int unsigned cut;
    int unsigned tick_odds;
    paylen = ($urandom_range(0, 40) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
    fault  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    len_b  = 8'(paylen + 2);
    code_b = sent_cmd + 8'd1;
    sum    = host_dir + code_b;
    frame_q.push_back(ZERO_BYTE);
    frame_q.push_back(ZERO_BYTE);
    frame_q.push_back(START_CODE);
    frame_q.push_back(len_b);
    frame_q.push_back(8'd0 - len_b);
    frame_q.push_back(host_dir);
    frame_q.push_back(code_b);
    for (int i = 0; i < paylen; i++) begin
      pb  = 8'($urandom_range(0, 255));
      sum = sum + pb;
      frame_q.push_back(pb);
    end
    frame_q.push_back(8'd0 - sum);
    frame_q.push_back(ZERO_BYTE);

    // Corrupt one field, or cut the frame short
    flip = 8'($urandom_range(1, 255));
    cut  = frame_q.size();
    case (fault)
      1: frame_q[$urandom_range(0, 2)] = frame_q[0] ^ flip;
      2: frame_q[4] = frame_q[4] ^ flip;
      3: frame_q[5] = frame_q[5] ^ flip;
      4: frame_q[6] = frame_q[6] ^ flip;
      5: frame_q[cut-2] = frame_q[cut-2] ^ flip;
      6: frame_q[cut-1] = frame_q[cut-1] ^ flip;
      7: cut = $urandom_range(1, cut - 1);
      default: ;
    endcase

    tick_odds = (timeout_cfg < 16'd8) ? 10 : 25;
    frame_request(CMD_START, 8'($urandom_range(0, 255)));
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, tick_odds) == 0)
        frame_request(CMD_TICK, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 60) == 0) offer_request(CMD_UNUSED, 8'($urandom_range(0, 255)));
      frame_request(CMD_BYTE, frame_q[i]);
    end
    if (fault == 7) repeat ($urandom_range(0, 8)) frame_request(CMD_TICK, 8'd0);
    if ($urandom_range(0, 5) == 0) offer_request(CMD_BYTE, 8'($urandom_range(0, 255)));
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned target;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.cmd     = CMD_BYTE;
    req_if.rx_byte = 8'd0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_SENT_COMMAND;
    cfg_data_i     = '0;
    long_hold_q    = 1'b0;
    frame_items    = 0;
    burst_left     = 0;
    gaps_on        = 1'b1;
    sent_cmd       = RST_SENT_COMMAND;
    buf_cap        = RST_BUFFER_CAP;
    timeout_cfg    = RST_TIMEOUT;
    host_dir       = RST_HOST_DIR;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    set_config(8'd255, 8'd0, 16'd1, RST_HOST_DIR);
    for (int i = 0; i < DIRECTED_LEN; i++) frame_request(DIRECTED[i][9:8], DIRECTED[i][7:0]);

    // Random part, one register setting per pass
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      // push the parser back to idle with a failing preamble
      frame_request(CMD_START, 8'd0);
      repeat (3) frame_request(CMD_BYTE, 8'h01);
      case (p)
        0: set_config(8'($urandom_range(0, 255)), 8'd255, 16'd0,
                      8'($urandom_range(0, 255)));
        1: set_config(8'd0, 8'($urandom_range(0, 16)), 16'hFFFF, 8'd0);
        2: set_config(8'($urandom_range(0, 255)), 8'd255, 16'($urandom_range(2, 5)),
                      RST_HOST_DIR);
        3: set_config(8'd254, 8'($urandom_range(4, 255)), RST_TIMEOUT, 8'd255);
        4: set_config(8'd255, 8'd0, 16'd1, 8'($urandom_range(0, 255)));
        default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      endcase
      if (p == 0) long_hold_q <= 1'b1;
      target = frame_items + RUN_ITEMS / NUM_SETTINGS;
      while (frame_items < target) begin
        gaps_on = ($urandom_range(0, 4) != 0);
        send_frame();
      end
    end

    // Drain
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
design/nfcp_pkg.sv
design/nfcp_if.sv
design/nfcp_out_stage.sv
design/nfc_response_frame_parser.sv
verif/nfcp_frame_checker.sv
verif/testbench.sv
